@@ hdl/tdba_pkg.sv @@
// shared types, codes and constants for the top-down block allocator
package tdba_pkg;

  localparam int MAX_BLOCKS_DEF   = 32;
  localparam int HEADER_BYTES_DEF = 12;

  localparam logic [31:0] HEAP_BASE_RST = 32'h01e0_0000;
  localparam logic [31:0] HEAP_END_RST  = 32'h01f0_0000;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_END  = 2'd1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
  localparam logic [2:0] ST_NO_SPACE  = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic        valid;
    logic [31:0] start;
    logic [31:0] bytes;
  } entry_t;

endpackage

@@ hdl/top_down_block_allocator_core.sv @@
// top level: ring of table cells with the scan controller at the head cell
// sequence: a bad size goes straight to the done state; a free makes one table pass; an allocate
// makes one scan pass per candidate position, and a write pass when it is placed
// throughput: one item at a time; each table pass rotates the cell ring once
// a finished word waits in the output register while the next item is accepted
// reset: synchronous, clears all entries and loads heap_base/heap_end defaults
module top_down_block_allocator_core #(
  parameter int MAX_BLOCKS   = tdba_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = tdba_pkg::HEADER_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_cmd,
  input  logic signed [31:0]             in_req_size,
  input  logic [31:0]                    in_free_addr,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [31:0]                    out_payload_addr,
  output logic [2:0]                     out_status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tdba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);
  import tdba_pkg::*;

  localparam int CNT_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_BLOCKS - 1);
  localparam logic [33:0] HDR34 = 34'(HEADER_BYTES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_FREE  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [31:0]      heap_base_r, heap_end_r;
  logic [33:0]      cs_r, cs_nxt;
  logic [31:0]      ce_r, ce_nxt;
  logic [32:0]      total_r;
  logic [31:0]      size_r, faddr_r;
  logic             hit_r, hit_nxt, free_r, first_r;
  logic [31:0]      hitst_r, hitst_nxt;
  logic [31:0]      res_addr_r, res_addr_nxt;
  logic [2:0]       res_status_r, res_status_nxt;
  logic             out_valid_r;
  logic [31:0]      out_addr_r;
  logic [2:0]       out_status_r;

  entry_t q [MAX_BLOCKS];
  entry_t head_mod;
  logic   shift;

  assign shift = (state_r == S_SCAN) || (state_r == S_WRITE) || (state_r == S_FREE);

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    entry_t d;
    if (i == MAX_BLOCKS - 1) begin : g_tail
      assign d = head_mod;
    end else begin : g_mid
      assign d = q[i+1];
    end
    tdba_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift), .d(d), .q(q[i]));
  end

  logic        in_acc, pass_end;
  logic [33:0] head_pe, cs_try;
  logic        head_hit, free_match, free_now;
  logic [33:0] size34;

  assign in_acc   = in_valid && !in_stall;
  assign pass_end = (cnt_r == CNT_LAST);
  assign head_pe  = {2'b0, q[0].start} + {2'b0, q[0].bytes} + HDR34;
  assign head_hit = q[0].valid && ($signed(cs_r) < $signed(head_pe)) && (q[0].start < ce_r);
  assign free_match = q[0].valid && (({2'b0, q[0].start} + HDR34) == {2'b0, faddr_r});
  assign free_now = free_r || !q[0].valid;
  assign cs_try   = {2'b0, hitst_nxt} - {1'b0, total_r};
  assign size34   = {2'b0, in_req_size};

  // head entry as it re-enters the ring at the tail
  always_comb begin
    head_mod = q[0];
    if (state_r == S_WRITE && !q[0].valid && !hit_r) begin
      head_mod = '{valid: 1'b1, start: cs_r[31:0], bytes: size_r};
    end else if (state_r == S_FREE && free_match && !hit_r) begin
      head_mod.valid = 1'b0;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cs_nxt         = cs_r;
    ce_nxt         = ce_r;
    hit_nxt        = hit_r;
    hitst_nxt      = hitst_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          hit_nxt      = 1'b0;
          res_addr_nxt = '0;
          if (in_cmd == CMD_FREE) begin
            state_nxt = S_FREE;
          end else if (in_req_size <= 0) begin
            res_status_nxt = ST_BAD_SIZE;
            state_nxt      = S_DONE;
          end else begin
            ce_nxt    = heap_end_r;
            cs_nxt    = {2'b0, heap_end_r} - (size34 + HDR34);
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (head_hit && !hit_r) begin
          hit_nxt   = 1'b1;
          hitst_nxt = q[0].start;
        end
        if (pass_end) begin
          hit_nxt = 1'b0;
          if (first_r && !free_now) begin
            res_status_nxt = ST_FULL;
            state_nxt      = S_DONE;
          end else if ($signed(cs_r) < $signed({2'b0, heap_base_r})) begin
            res_status_nxt = ST_NO_SPACE;
            state_nxt      = S_DONE;
          end else if (head_hit || hit_r) begin
            ce_nxt = hitst_nxt;
            cs_nxt = cs_try;
            // next pass scans the moved candidate
          end else begin
            state_nxt = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        if (!q[0].valid) hit_nxt = 1'b1;
        if (pass_end) begin
          res_status_nxt = ST_OK;
          res_addr_nxt   = 32'(cs_r + HDR34);
          state_nxt      = S_DONE;
        end
      end
      S_FREE: begin
        if (free_match) hit_nxt = 1'b1;
        if (pass_end) begin
          res_status_nxt = (hit_r || free_match) ? ST_OK : ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      heap_base_r <= HEAP_BASE_RST;
      heap_end_r  <= HEAP_END_RST;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= (shift && !pass_end) ? cnt_r + 1'b1 : '0;
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_HEAP_BASE) heap_base_r <= cfg_data;
        if (cfg_index == REG_HEAP_END)  heap_end_r  <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cs_r         <= cs_nxt;
    ce_r         <= ce_nxt;
    hit_r        <= hit_nxt;
    hitst_r      <= hitst_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    if (in_acc) begin
      total_r <= 33'(size34 + HDR34);
      size_r  <= in_req_size;
      faddr_r <= in_free_addr;
      first_r <= 1'b1;
      free_r  <= 1'b0;
    end else if (state_r == S_SCAN) begin
      free_r <= free_now;
      if (pass_end) begin
        first_r <= 1'b0;
        free_r  <= 1'b0;
      end
    end
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= res_status_r;
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_payload_addr = out_addr_r;
  assign out_status       = out_status_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("accepted word did not make the block busy");
  a_addr_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_payload_addr == 32'd0)
    else $error("failed request carries an address");
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !shift |-> cnt_r == '0)
    else $error("ring position lost outside a pass");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_NOT_FOUND)
    else $error("status code out of range");

endmodule

@@ hdl/tdba_cell.sv @@
// one block table entry in the rotating ring
module tdba_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift,
  input  tdba_pkg::entry_t d,
  output tdba_pkg::entry_t q
);
  import tdba_pkg::*;

  logic        valid_r;
  logic [31:0] start_r;
  logic [31:0] bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      start_r <= d.start;
      bytes_r <= d.bytes;
    end
  end

  assign q = '{valid: valid_r, start: start_r, bytes: bytes_r};

endmodule

@@ tb/sv/tb.sv @@
// testbench for the top-down block allocator core: directed and random alloc/free checks
module tb;
  import tdba_pkg::*;

  localparam int NBLK = MAX_BLOCKS_DEF;
  localparam longint HDR = HEADER_BYTES_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [31:0] addr;
    logic [2:0]  status;
  } alloc_word_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_cmd;
  logic signed [31:0] in_req_size;
  logic [31:0] in_free_addr;
  logic out_valid;
  logic out_stall;
  logic [31:0] out_payload_addr;
  logic [2:0] out_status;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  // predictor state
  logic [31:0] pr_base;
  logic [31:0] pr_end;
  bit          blk_live[NBLK];
  logic [31:0] blk_start[NBLK];
  logic [31:0] blk_bytes[NBLK];

  alloc_word_t pending_words[$];
  int errors;
  bit tx_idle;
  bit rx_idle;
  bit long_hold;
  int stuck_cycles;

  top_down_block_allocator_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_req_size(in_req_size), .in_free_addr(in_free_addr),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_payload_addr(out_payload_addr), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit overlap_hit(longint cs, longint ce, output int idx);
    longint ps;
    longint pe;
    for (int i = 0; i < NBLK; i++) begin
      if (blk_live[i]) begin
        ps = longint'(blk_start[i]);
        pe = ps + longint'(blk_bytes[i]) + HDR;
        if (cs < pe && ps < ce) begin
          idx = i;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic alloc_word_t predict_alloc(logic [31:0] raw);
    alloc_word_t w;
    int slot;
    int hit;
    longint total;
    longint cs;
    longint ce;
    w.addr = '0;
    slot = -1;
    if (raw[31] || raw == 32'd0) begin
      w.status = ST_BAD_SIZE;
      return w;
    end
    for (int i = NBLK - 1; i >= 0; i--)
      if (!blk_live[i]) slot = i;
    if (slot < 0) begin
      w.status = ST_FULL;
      return w;
    end
    total = longint'(raw) + HDR;
    ce = longint'(pr_end);
    cs = ce - total;
    forever begin
      if (cs < longint'(pr_base)) begin
        w.status = ST_NO_SPACE;
        return w;
      end
      if (!overlap_hit(cs, ce, hit)) break;
      ce = longint'(blk_start[hit]);
      cs = ce - total;
    end
    blk_live[slot] = 1'b1;
    blk_start[slot] = cs[31:0];
    blk_bytes[slot] = raw;
    w.addr = cs[31:0] + 32'(HDR);
    w.status = ST_OK;
    return w;
  endfunction

  function automatic alloc_word_t predict_free(logic [31:0] a);
    alloc_word_t w;
    w.addr = '0;
    w.status = ST_NOT_FOUND;
    for (int i = 0; i < NBLK; i++) begin
      if (blk_live[i] && longint'(blk_start[i]) + HDR == longint'(a)) begin
        blk_live[i] = 1'b0;
        w.status = ST_OK;
        return w;
      end
    end
    return w;
  endfunction

  // payload address of a random live block, if any
  function automatic bit pick_live(output logic [31:0] a);
    int live_idx[$];
    for (int i = 0; i < NBLK; i++)
      if (blk_live[i]) live_idx.push_back(i);
    if (live_idx.size() == 0) return 1'b0;
    a = blk_start[live_idx[$urandom_range(0, live_idx.size() - 1)]] + 32'(HDR);
    return 1'b1;
  endfunction

  task automatic send_word(logic cmd, logic [31:0] size, logic [31:0] faddr);
    int gap;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_req_size <= size;
    in_free_addr <= faddr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd == CMD_ALLOC) pending_words.push_back(predict_alloc(size));
    else pending_words.push_back(predict_free(faddr));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_HEAP_BASE) pr_base = data;
    else pr_end = data;
  endtask

  task automatic set_region(logic [31:0] b, logic [31:0] e);
    drain();
    write_reg(REG_HEAP_BASE, b);
    write_reg(REG_HEAP_END, e);
  endtask

  task automatic free_all();
    logic [31:0] a;
    while (pick_live(a)) send_word(CMD_FREE, 32'd0, a);
  endtask

  task automatic test_sizes();
    logic [31:0] a;
    send_word(CMD_ALLOC, 32'd0, 32'hffff_ffff);
    send_word(CMD_ALLOC, 32'hffff_ffff, 32'd0);
    send_word(CMD_ALLOC, 32'h8000_0000, 32'd0);
    send_word(CMD_ALLOC, 32'h7fff_ffff, 32'd0);
    send_word(CMD_ALLOC, 32'd1, 32'd0);
    send_word(CMD_ALLOC, 32'h000f_fff4, 32'd0);  // would exactly fill the empty region; the live block leaves no space
    send_word(CMD_FREE, 32'hffff_ffff, 32'd0);
    send_word(CMD_FREE, 32'h8000_0000, 32'hffff_ffff);
    void'(pick_live(a));
    send_word(CMD_FREE, 32'd0, a);
    send_word(CMD_FREE, 32'd0, a);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < NBLK; i++) send_word(CMD_ALLOC, 32'd16, 32'd0);
    send_word(CMD_ALLOC, 32'd16, 32'd0);
    send_word(CMD_ALLOC, 32'd0, 32'd0);
    free_all();
  endtask

  task automatic test_region_extremes();
    set_region(32'd0, 32'hffff_ffff);
    send_word(CMD_ALLOC, 32'h7fff_ffff, 32'd0);
    send_word(CMD_ALLOC, 32'h7fff_ffff, 32'd0);
    send_word(CMD_ALLOC, 32'd1, 32'd0);
    // region moved away while blocks stay live
    set_region(32'h7fff_0000, 32'hffff_ffff);
    send_word(CMD_ALLOC, 32'd100, 32'd0);
    set_region(32'h0000_0100, 32'h0000_0080);
    send_word(CMD_ALLOC, 32'd1, 32'd0);
    set_region(32'h0000_1000, 32'h0000_1000);
    send_word(CMD_ALLOC, 32'd1, 32'd0);
    set_region(32'h0000_1000, 32'h0000_100d);
    send_word(CMD_ALLOC, 32'd1, 32'd0);
    send_word(CMD_ALLOC, 32'd1, 32'd0);
    free_all();
  endtask

  task automatic random_word();
    int r;
    logic [31:0] a;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      send_word(CMD_ALLOC, $urandom_range(1, 200), $urandom);
    end else if (r < 55) begin
      send_word(CMD_ALLOC, {1'b0, 31'($urandom)}, $urandom);
    end else if (r < 60) begin
      send_word(CMD_ALLOC, (r < 57) ? 32'd0 : ($urandom | 32'h8000_0000), $urandom);
    end else if (r < 90 && pick_live(a)) begin
      send_word(CMD_FREE, $urandom, a);
    end else begin
      a = (r < 95) ? $urandom : $urandom_range(32'h1000, 32'h3000);
      send_word(CMD_FREE, $urandom, a);
    end
  endtask

  task automatic test_random_phase(logic [31:0] b, logic [31:0] e, int count, int mode);
    set_region(b, e);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        tx_idle = $urandom_range(0, 2) != 0;
        rx_idle = $urandom_range(0, 2) != 0;
      end
      if (mode == 1 && i == count / 2) long_hold = 1'b1;
      if (mode == 2 && i == count / 2) drain();
      random_word();
    end
  endtask

  // result side: random stall per word, one long hold on request
  initial begin
    int n;
    out_stall = 1'b1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        n = rx_idle ? $urandom_range(0, 8) : 0;
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    alloc_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word addr=%h status=%0d", $time, out_payload_addr,
                 out_status);
        errors++;
      end else begin
        w = pending_words.pop_front();
        if (out_payload_addr !== w.addr) begin
          $display("%0t: payload_addr expected %h actual %h", $time, w.addr,
                   out_payload_addr);
          errors++;
        end
        if (out_status !== w.status) begin
          $display("%0t: status expected %0d actual %0d", $time, w.status, out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    errors = 0;
    stuck_cycles = 0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    long_hold = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_cmd <= CMD_ALLOC;
    in_req_size <= '0;
    in_free_addr <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_HEAP_BASE;
    cfg_data <= '0;
    pr_base = HEAP_BASE_RST;
    pr_end = HEAP_END_RST;
    for (int i = 0; i < NBLK; i++) begin
      blk_live[i] = 1'b0;
      blk_start[i] = '0;
      blk_bytes[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_sizes();
    test_table_full();
    test_region_extremes();
    test_random_phase(32'h0000_2000, 32'h0000_3000, 300, 0);
    test_random_phase(32'h0000_2000, 32'h0000_2400, 250, 1);
    test_random_phase(32'hffff_f000, 32'hffff_ffff, 250, 2);
    test_random_phase(HEAP_BASE_RST, HEAP_BASE_RST + 32'h1800, 300, 0);
    drain();

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
